// ===== rtl/core/refcounted_handle_pool_unit_assert.svh =====
// assertion macros for the refcounted handle pool unit
// used by the port checker; depends on nothing else
`ifndef REFCOUNTED_HANDLE_POOL_UNIT_ASSERT_SVH
`define REFCOUNTED_HANDLE_POOL_UNIT_ASSERT_SVH

// same-cycle implication, checked on every clock edge outside reset
`define RHP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rhp check failed: same cycle");

// next-cycle implication
`define RHP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rhp check failed: next cycle");

`endif

// ===== rtl/core/rhp_pkg.sv =====
// shared types and constants for the refcounted handle pool unit
// no dependencies
package rhp_pkg;

   localparam int POOL_SIZE   = 8192;
   localparam int COUNT_BITS  = 16;
   localparam int ADDR_BITS   = $clog2(POOL_SIZE);
   localparam int HANDLE_BITS = $clog2(POOL_SIZE + 1);

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_PUT    = 2'd2;
   localparam logic [1:0] OP_LOOKUP = 2'd3;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_BAD   = 2'd2;
   localparam logic [1:0] STS_SAT   = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // everything one operation decides: result word, memory writes, new pointers
   typedef struct packed {
      logic [1:0]             status;
      logic [HANDLE_BITS-1:0] handle_out;
      logic [COUNT_BITS-1:0]  refcnt;
      logic                   freed;
      logic                   cnt_we;
      logic [ADDR_BITS-1:0]   cnt_addr;
      logic [COUNT_BITS-1:0]  cnt_wdata;
      logic                   link_we;
      logic [ADDR_BITS-1:0]   link_addr;
      logic [HANDLE_BITS-1:0] link_wdata;
      logic [HANDLE_BITS-1:0] free_top;
      logic [HANDLE_BITS-1:0] never_used;
   } upd_type;

endpackage

// ===== rtl/core/rhp_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module rhp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rhp_update.sv =====
// per-operation decision logic: liveness, count update, free stack push/pop
// depends on rhp_pkg
module rhp_update
   import rhp_pkg::*;
(
   input  logic [1:0]             opcode,
   input  logic [HANDLE_BITS-1:0] handle,
   input  logic [COUNT_BITS-1:0]  cnt_rd,
   input  logic [HANDLE_BITS-1:0] link_rd,
   input  logic [HANDLE_BITS-1:0] free_top,
   input  logic [HANDLE_BITS-1:0] never_used,
   output upd_type                upd
);

   logic [HANDLE_BITS-1:0] got;
   logic [HANDLE_BITS-1:0] got_m1;
   logic [HANDLE_BITS-1:0] hdl_m1;
   logic [COUNT_BITS-1:0]  cnt_dec;
   logic [COUNT_BITS-1:0]  cnt_inc;
   logic                   live;

   always_comb begin
      got     = (free_top != '0) ? free_top : never_used + HANDLE_BITS'(1);
      got_m1  = got - HANDLE_BITS'(1);
      hdl_m1  = handle - HANDLE_BITS'(1);
      cnt_dec = cnt_rd - COUNT_BITS'(1);
      cnt_inc = cnt_rd + COUNT_BITS'(1);
      // never_used never exceeds the pool size, so this covers the range check
      live    = (handle != '0) && (handle <= never_used) && (cnt_rd != '0);

      upd            = '0;
      upd.handle_out = handle;
      upd.cnt_addr   = hdl_m1[ADDR_BITS-1:0];
      upd.link_addr  = hdl_m1[ADDR_BITS-1:0];
      upd.link_wdata = free_top;
      upd.free_top   = free_top;
      upd.never_used = never_used;

      if (opcode == OP_ALLOC) begin
         if (free_top == '0 && never_used == HANDLE_BITS'(POOL_SIZE)) begin
            upd.status     = STS_EMPTY;
            upd.handle_out = '0;
         end else begin
            upd.status     = STS_OK;
            upd.handle_out = got;
            upd.refcnt     = COUNT_BITS'(1);
            upd.cnt_we     = 1'b1;
            upd.cnt_addr   = got_m1[ADDR_BITS-1:0];
            upd.cnt_wdata  = COUNT_BITS'(1);
            if (free_top != '0) begin
               upd.free_top = link_rd;
            end else begin
               upd.never_used = got;
            end
         end
      end else if (!live) begin
         upd.status = STS_BAD;
      end else if (opcode == OP_PUT) begin
         upd.status    = STS_OK;
         upd.cnt_we    = 1'b1;
         upd.cnt_wdata = cnt_dec;
         upd.refcnt    = cnt_dec;
         if (cnt_dec == '0) begin
            upd.freed    = 1'b1;
            upd.link_we  = 1'b1;
            upd.free_top = handle;
         end
      end else if (cnt_rd == '1) begin
         upd.status = STS_SAT;
         upd.refcnt = cnt_rd;
      end else begin
         upd.status    = STS_OK;
         upd.cnt_we    = 1'b1;
         upd.cnt_wdata = cnt_inc;
         upd.refcnt    = cnt_inc;
      end
   end

endmodule

// ===== rtl/core/refcounted_handle_pool_unit.sv =====
// top level of the refcounted handle pool: two rams, sequencer, result register
// depends on rhp_pkg, rhp_ram, rhp_update
//
//   channel  direction  fields                                   handshake
//   req      in         opcode, handle                           req_valid / req_stall
//   rsp      out        status, handle_out, refcnt, freed        rsp_valid / rsp_stall
//
// the accepting cycle issues the count and link ram reads, the next cycle
// gets the registered read data, writes back and loads the result register;
// that ram round trip sets the rate
// a new word is taken while a finished result still waits in the output
// register; the write-back is held only while that register is full and stalled
// synchronous reset empties the free stack and the never-used counter; no ram clearing
module refcounted_handle_pool_unit
   import rhp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_opcode,
   input  logic [HANDLE_BITS-1:0] req_handle,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_handle_out,
   output logic [COUNT_BITS-1:0]  rsp_refcnt,
   output logic                   rsp_freed
);

   // sequencer state
   state_type state_ff, state_in;

   // operation held for the write-back cycle
   logic [1:0]             opcode_ff, opcode_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;

   // free stack top (0 = empty) and count of handles taken from the never-used region
   logic [HANDLE_BITS-1:0] free_top_ff, free_top_in;
   logic [HANDLE_BITS-1:0] never_used_ff, never_used_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                   rsp_freed_ff, rsp_freed_in;

   logic                   accept;
   logic                   commit;
   logic                   out_free;
   logic [HANDLE_BITS-1:0] req_hdl_m1;
   logic [HANDLE_BITS-1:0] top_m1;
   logic [COUNT_BITS-1:0]  cnt_rd;
   logic [HANDLE_BITS-1:0] link_rd;
   upd_type                upd;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == ST_EXEC) && out_free;

   // read addresses come straight from the request word and the current stack top
   assign req_hdl_m1 = req_handle - HANDLE_BITS'(1);
   assign top_m1     = free_top_ff - HANDLE_BITS'(1);

   // reference counts, indexed by handle - 1
   rhp_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (POOL_SIZE)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (commit && upd.cnt_we),
      .wr_addr (upd.cnt_addr),
      .wr_data (upd.cnt_wdata),
      .rd_en   (accept),
      .rd_addr (req_hdl_m1[ADDR_BITS-1:0]),
      .rd_data (cnt_rd)
   );

   // free stack links, indexed by handle - 1; 0 ends the stack
   rhp_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (POOL_SIZE)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (commit && upd.link_we),
      .wr_addr (upd.link_addr),
      .wr_data (upd.link_wdata),
      .rd_en   (accept),
      .rd_addr (top_m1[ADDR_BITS-1:0]),
      .rd_data (link_rd)
   );

   rhp_update u_update (
      .opcode     (opcode_ff),
      .handle     (handle_ff),
      .cnt_rd     (cnt_rd),
      .link_rd    (link_rd),
      .free_top   (free_top_ff),
      .never_used (never_used_ff),
      .upd        (upd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_EXEC: req_stall = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   // datapath next values
   always_comb begin
      opcode_in     = accept ? req_opcode : opcode_ff;
      handle_in     = accept ? req_handle : handle_ff;
      free_top_in   = commit ? upd.free_top : free_top_ff;
      never_used_in = commit ? upd.never_used : never_used_ff;

      rsp_valid_in  = commit ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_status_in = commit ? upd.status : rsp_status_ff;
      rsp_handle_in = commit ? upd.handle_out : rsp_handle_ff;
      rsp_count_in  = commit ? upd.refcnt : rsp_count_ff;
      rsp_freed_in  = commit ? upd.freed : rsp_freed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_top_ff   <= '0;
         never_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_top_ff   <= free_top_in;
         never_used_ff <= never_used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      opcode_ff     <= opcode_in;
      handle_ff     <= handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_refcnt     = rsp_count_ff;
   assign rsp_freed      = rsp_freed_ff;

endmodule

// ===== rtl/core/rhp_checker.sv =====
// port-level checks for the refcounted handle pool unit, bound to the top level
// depends on rhp_pkg and refcounted_handle_pool_unit_assert.svh
`include "refcounted_handle_pool_unit_assert.svh"

module rhp_checker
   import rhp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [1:0]             req_opcode,
   input logic [HANDLE_BITS-1:0] req_handle,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [1:0]             rsp_status,
   input logic [HANDLE_BITS-1:0] rsp_handle_out,
   input logic [COUNT_BITS-1:0]  rsp_refcnt,
   input logic                   rsp_freed
);

   // a stalled result word stays offered
   `RHP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // the cycle after a request word is taken the block is busy
   `RHP_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // a failed allocation reports no handle and no count
   `RHP_ASSERT_NOW(a_empty_zero, rsp_valid && rsp_status == STS_EMPTY,
      rsp_handle_out == '0 && rsp_refcnt == '0 && !rsp_freed)

   // freeing only comes from a successful put that reached zero
   `RHP_ASSERT_NOW(a_freed_ok, rsp_valid && rsp_freed,
      rsp_status == STS_OK && rsp_refcnt == '0 && rsp_handle_out != '0)

   // a live handle that was not freed keeps a nonzero count
   `RHP_ASSERT_NOW(a_ok_live, rsp_valid && rsp_status == STS_OK && !rsp_freed,
      rsp_refcnt != '0)

endmodule

bind refcounted_handle_pool_unit rhp_checker u_rhp_checker (.*);

// ===== dv/refcounted_handle_pool_unit_tb.sv =====
// self-checking testbench for the refcounted handle pool unit: directed, random
// and backpressure traffic against a local predictor
// depends on rhp_pkg and refcounted_handle_pool_unit
module refcounted_handle_pool_unit_tb
   import rhp_pkg::*;
;

   localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
   localparam int HANDLE_TOP   = (1 << HANDLE_BITS) - 1;
   localparam int RANDOM_WORDS = 760;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_SLACK  = 8;
   localparam int DRAIN_GUARD  = 20000;
   localparam int PRINT_CAP    = 50;

   // one result word as the pool should answer it
   typedef struct {
      logic [1:0]             status;
      logic [HANDLE_BITS-1:0] handle;
      logic [COUNT_BITS-1:0]  count;
      logic                   freed;
   } pool_answer_type;

   // dut ports; the inputs are known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_opcode = OP_ALLOC;
   logic [HANDLE_BITS-1:0] req_handle = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_status;
   logic [HANDLE_BITS-1:0] rsp_handle_out;
   logic [COUNT_BITS-1:0]  rsp_refcnt;
   logic                   rsp_freed;

   // predictor copy of the pool: counts, free-stack links, stack top, fresh region
   logic [COUNT_BITS-1:0]  model_counts [1:POOL_SIZE];
   logic [HANDLE_BITS-1:0] model_links  [1:POOL_SIZE];
   int                     model_top   = 0;
   int                     model_fresh = 0;

   pool_answer_type pending_answers [$];

   int  mismatches      = 0;
   int  words_sent      = 0;
   int  results_checked = 0;
   bit  idle_on         = 1'b1;
   int  hold_requests   = 0;
   int  holds_done      = 0;
   int  stall_left      = 0;

   refcounted_handle_pool_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_handle     (req_handle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_refcnt     (rsp_refcnt),
      .rsp_freed      (rsp_freed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("refcounted_handle_pool_unit_tb NOT OK");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // advance the pool copy by one operation and return the answer it gives
   function automatic pool_answer_type compute_pool_answer(logic [1:0] op,
                                                           logic [HANDLE_BITS-1:0] h);
      pool_answer_type a;
      int              got;
      a.status = STS_OK;
      a.handle = h;
      a.count  = '0;
      a.freed  = 1'b0;
      if (op == OP_ALLOC) begin
         a.handle = '0;
         // most recently freed first, then the lowest never-used handle
         if (model_top != 0) begin
            got       = model_top;
            model_top = model_links[got];
         end else if (model_fresh < POOL_SIZE) begin
            model_fresh = model_fresh + 1;
            got         = model_fresh;
         end else begin
            a.status = STS_EMPTY;
            return a;
         end
         model_counts[got] = COUNT_BITS'(1);
         a.handle = HANDLE_BITS'(got);
         a.count  = COUNT_BITS'(1);
      end else if (h == 0 || h > model_fresh || model_counts[h] == 0) begin
         // out of range, never handed out, or already freed
         a.status = STS_BAD;
      end else if (op == OP_PUT) begin
         model_counts[h] = model_counts[h] - COUNT_BITS'(1);
         a.count = model_counts[h];
         if (model_counts[h] == 0) begin
            model_links[h] = HANDLE_BITS'(model_top);
            model_top      = h;
            a.freed        = 1'b1;
         end
      end else if (model_counts[h] == COUNT_MAX) begin
         // get or lookup on a full count holds it
         a.status = STS_SAT;
         a.count  = model_counts[h];
      end else begin
         model_counts[h] = model_counts[h] + COUNT_BITS'(1);
         a.count = model_counts[h];
      end
      return a;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("mismatch at result %0d: %s got %0d want %0d",
                  results_checked, what, got, want);
   endtask

   // result check first, then prediction of any word taken at this edge,
   // so queue order never depends on process scheduling
   always @(posedge clock) begin
      pool_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected word, status", rsp_status, -1);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_handle_out !== want.handle)
               report_mismatch("handle_out", rsp_handle_out, want.handle);
            if (rsp_refcnt !== want.count)
               report_mismatch("refcnt", rsp_refcnt, want.count);
            if (rsp_freed !== want.freed)
               report_mismatch("freed", rsp_freed, want.freed);
         end
         results_checked++;
      end
      if (!reset && req_valid && !req_stall)
         pending_answers.push_back(compute_pool_answer(req_opcode, req_handle));
   end

   // receiver: random stalls while idling is on, and a long counted hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            if (holds_done != hold_requests) begin
               holds_done = holds_done + 1;
               stall_left = LONG_HOLD;
            end else if (idle_on) begin
               stall_left = pick_gap();
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left = stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one word, after an optional gap with junk on the idle payload lines
   task automatic send_word(logic [1:0] op, logic [HANDLE_BITS-1:0] h);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid  <= 1'b0;
         req_opcode <= 2'($urandom_range(0, 3));
         req_handle <= HANDLE_BITS'($urandom_range(0, HANDLE_TOP));
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_handle <= h;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // stop offering and let every expected word come back
   task automatic wait_drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_answers.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // bad handles, allocation order, count up and down, lifo reuse of freed handles
   task automatic test_directed_cases();
      idle_on = 1'b1;
      send_word(OP_GET, '0);                                 // handle zero
      send_word(OP_PUT, 14'd1);                              // never handed out
      send_word(OP_LOOKUP, HANDLE_BITS'(HANDLE_TOP));        // far out of range
      send_word(OP_GET, HANDLE_BITS'(POOL_SIZE + 1));        // just past the pool
      send_word(OP_ALLOC, HANDLE_BITS'(HANDLE_TOP));         // handle field ignored -> 1
      send_word(OP_ALLOC, '0);                               // -> 2
      send_word(OP_ALLOC, '0);                               // -> 3
      send_word(OP_GET, 14'd1);
      send_word(OP_LOOKUP, 14'd1);
      send_word(OP_PUT, 14'd1);
      send_word(OP_PUT, 14'd1);
      send_word(OP_PUT, 14'd1);                              // count hits zero, freed
      send_word(OP_PUT, 14'd1);                              // dead handle
      send_word(OP_GET, 14'd1);
      send_word(OP_LOOKUP, 14'd1);
      send_word(OP_PUT, 14'd2);                              // stack now 2 then 1
      send_word(OP_ALLOC, '0);                               // -> 2
      send_word(OP_ALLOC, '0);                               // -> 1
      send_word(OP_ALLOC, '0);                               // -> 4 from the fresh region
      send_word(OP_PUT, 14'd3);
      send_word(OP_PUT, 14'd4);
      send_word(OP_ALLOC, '0);                               // -> 4
      send_word(OP_ALLOC, '0);                               // -> 3
      wait_drain();
   endtask

   // mostly live handles with random ops, some random handles as noise;
   // every fourth chunk runs with no idling on either side
   task automatic test_random_traffic();
      int                     r;
      logic [1:0]             op;
      logic [HANDLE_BITS-1:0] h;
      for (int chunk = 0; chunk < 8; chunk++) begin
         idle_on = (chunk % 4) != 3;
         repeat (RANDOM_WORDS / 8) begin
            r = $urandom_range(0, 99);
            if (r < 30)      op = OP_ALLOC;
            else if (r < 55) op = OP_GET;
            else if (r < 85) op = OP_PUT;
            else             op = OP_LOOKUP;
            if (model_fresh == 0 || $urandom_range(0, 99) < 8)
               h = HANDLE_BITS'($urandom_range(0, HANDLE_TOP));
            else
               h = HANDLE_BITS'($urandom_range(1, model_fresh));
            send_word(op, h);
         end
      end
      wait_drain();
   endtask

   // receiver holds off for a long stretch while words keep coming,
   // so the block fills and stalls its input
   task automatic test_output_backpressure();
      idle_on = 1'b0;
      hold_requests <= hold_requests + 1;
      repeat (24) begin
         if ($urandom_range(0, 1) == 0 || model_fresh == 0)
            send_word(OP_ALLOC, HANDLE_BITS'($urandom_range(0, HANDLE_TOP)));
         else
            send_word(OP_GET, HANDLE_BITS'($urandom_range(1, model_fresh)));
      end
      wait_drain();
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic();
      test_output_backpressure();
      if (pending_answers.size() != 0)
         report_mismatch("words never delivered", 0, pending_answers.size());
      $display("sent %0d words, checked %0d results", words_sent, results_checked);
      $display("covered bad handles, lifo reuse, random ops and a long receiver hold");
      if (mismatches == 0) begin
         $display("refcounted_handle_pool_unit_tb OK");
      end else begin
         $display("refcounted_handle_pool_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
